### hdl/stt_pkg.sv
// shared types and constants for the structured text tokenizer
// event word layout, event kinds and character codes; no dependencies
`default_nettype none

package stt_pkg;

	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;
	localparam int MAX_EV      = 4;
	localparam int EV_IDX_W    = $clog2(MAX_EV);
	localparam int EV_CNT_W    = $clog2(MAX_EV + 1);

	typedef enum logic [3:0] {
		EV_LBRACE   = 4'd0,
		EV_RBRACE   = 4'd1,
		EV_LBRACK   = 4'd2,
		EV_RBRACK   = 4'd3,
		EV_COMMA    = 4'd4,
		EV_COLON    = 4'd5,
		EV_HASH     = 4'd6,
		EV_ID_BEGIN = 4'd7,
		EV_ID_CHAR  = 4'd8,
		EV_ID_END   = 4'd9,
		EV_END      = 4'd10,
		EV_ERROR    = 4'd11
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t               kind;
		logic [7:0]             id_byte;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] column;
	} event_t;

	// all events raised by one input word
	typedef struct packed {
		event_t [MAX_EV-1:0]   ev;
		logic [EV_CNT_W-1:0]   count;
	} ev_bundle_t;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

endpackage

`default_nettype wire

### hdl/stt_lexer.sv
// lexer mode machine with line and column counters
// turns one input word into up to four events in a single pass; uses stt_pkg
`default_nettype none

module stt_lexer import stt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] in_byte,
	input  wire logic       eot,
	output ev_bundle_t      bundle
);

	typedef enum logic [6:0] {
		M_WS    = 7'b0000001,
		M_BARE  = 7'b0000010,
		M_SQ    = 7'b0000100,
		M_DQ    = 7'b0001000,
		M_LINE  = 7'b0010000,
		M_BLOCK = 7'b0100000,
		M_DONE  = 7'b1000000
	} lex_mode_t;

	lex_mode_t              mode_q, ret_q;
	logic                   sp_q, qp_q, star_q;
	logic [LINE_BITS-1:0]   line_q, hl_q;
	logic [COLUMN_BITS-1:0] col_q, hc_q;

	lex_mode_t              mode_v, ret_v;
	logic                   sp_v, qp_v, star_v, go;
	logic [LINE_BITS-1:0]   hl_v;
	logic [COLUMN_BITS-1:0] hc_v;
	logic [EV_CNT_W-1:0]    n;
	event_t [MAX_EV-1:0]    evs;

	function automatic event_t mk(input ev_kind_t k, input logic [7:0] b,
		input logic [LINE_BITS-1:0] l, input logic [COLUMN_BITS-1:0] cc);
		event_t e;
		e.kind = k;
		e.id_byte = b;
		e.line = l;
		e.column = cc;
		return e;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SPACE, [8'd9:8'd13]};
	endfunction

	function automatic logic is_special(input logic [7:0] c);
		return c inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA,
			CH_COLON, CH_HASH};
	endfunction

	function automatic ev_kind_t special_kind(input logic [7:0] c);
		ev_kind_t k;
		case (c)
			CH_LBRACE: k = EV_LBRACE;
			CH_RBRACE: k = EV_RBRACE;
			CH_LBRACK: k = EV_LBRACK;
			CH_RBRACK: k = EV_RBRACK;
			CH_COMMA:  k = EV_COMMA;
			CH_COLON:  k = EV_COLON;
			default:   k = EV_HASH;
		endcase
		return k;
	endfunction

	always_comb begin
		mode_v = mode_q;
		ret_v  = ret_q;
		sp_v   = sp_q;
		qp_v   = qp_q;
		star_v = star_q;
		hl_v   = hl_q;
		hc_v   = hc_q;
		n      = '0;
		evs    = '0;
		go     = 1'b1;
		if (eot) begin
			// an open line comment just closes
			if (mode_v == M_LINE) mode_v = ret_v;
			case (mode_v)
				M_WS: begin
					if (sp_v) begin
						evs[n[EV_IDX_W-1:0]] = mk(EV_ID_BEGIN, 8'd0, hl_v, hc_v);
						n = n + 1'b1;
						evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, CH_SLASH, hl_v, hc_v);
						n = n + 1'b1;
						evs[n[EV_IDX_W-1:0]] = mk(EV_ID_END, 8'd0, hl_v, hc_v);
						n = n + 1'b1;
					end
					evs[n[EV_IDX_W-1:0]] = mk(EV_END, 8'd0, line_q, col_q);
					n = n + 1'b1;
				end
				M_BARE: begin
					if (sp_v) begin
						evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, CH_SLASH, hl_v, hc_v);
						n = n + 1'b1;
					end
					evs[n[EV_IDX_W-1:0]] = mk(EV_ID_END, 8'd0, hl_v, hc_v);
					n = n + 1'b1;
					evs[n[EV_IDX_W-1:0]] = mk(EV_END, 8'd0, line_q, col_q);
					n = n + 1'b1;
				end
				M_SQ, M_DQ: begin
					if (qp_v) begin
						evs[n[EV_IDX_W-1:0]] = mk(EV_ID_END, 8'd0, hl_v, hc_v);
						n = n + 1'b1;
						evs[n[EV_IDX_W-1:0]] = mk(EV_END, 8'd0, line_q, col_q);
						n = n + 1'b1;
					end else begin
						evs[n[EV_IDX_W-1:0]] = mk(EV_ERROR, 8'd0, line_q, col_q);
						n = n + 1'b1;
					end
				end
				M_BLOCK: begin
					evs[n[EV_IDX_W-1:0]] = mk(EV_ERROR, 8'd0, line_q, col_q);
					n = n + 1'b1;
				end
				default: ;
			endcase
			if (mode_v != M_DONE) begin
				mode_v = M_DONE;
				sp_v   = 1'b0;
				qp_v   = 1'b0;
				star_v = 1'b0;
			end
		end else begin
			// a byte may be handed on to the next mode at most twice
			for (int i = 0; i < 3; i++) begin
				if (go) begin
					go = 1'b0;
					case (mode_v)
						M_WS: begin
							if (sp_v) begin
								sp_v = 1'b0;
								if (in_byte == CH_SLASH) begin
									mode_v = M_LINE;
									ret_v = M_WS;
								end else if (in_byte == CH_STAR) begin
									mode_v = M_BLOCK;
									ret_v = M_WS;
									star_v = 1'b0;
								end else begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_BEGIN, 8'd0, hl_v, hc_v);
									n = n + 1'b1;
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, CH_SLASH, hl_v, hc_v);
									n = n + 1'b1;
									mode_v = M_BARE;
									go = 1'b1;
								end
							end else if (is_space(in_byte)) begin
								go = 1'b0;
							end else if (in_byte == CH_SLASH) begin
								sp_v = 1'b1;
								hl_v = line_q;
								hc_v = col_q;
							end else if (is_special(in_byte)) begin
								evs[n[EV_IDX_W-1:0]] = mk(special_kind(in_byte), 8'd0,
									line_q, col_q);
								n = n + 1'b1;
							end else begin
								hl_v = line_q;
								hc_v = col_q;
								evs[n[EV_IDX_W-1:0]] = mk(EV_ID_BEGIN, 8'd0, line_q, col_q);
								n = n + 1'b1;
								qp_v = 1'b0;
								if (in_byte == CH_SQUOTE) begin
									mode_v = M_SQ;
								end else if (in_byte == CH_DQUOTE) begin
									mode_v = M_DQ;
								end else begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, in_byte, line_q, col_q);
									n = n + 1'b1;
									mode_v = M_BARE;
								end
							end
						end
						M_BARE: begin
							if (sp_v) begin
								sp_v = 1'b0;
								if (in_byte == CH_SLASH) begin
									mode_v = M_LINE;
									ret_v = M_BARE;
								end else if (in_byte == CH_STAR) begin
									mode_v = M_BLOCK;
									ret_v = M_BARE;
									star_v = 1'b0;
								end else begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, CH_SLASH, hl_v, hc_v);
									n = n + 1'b1;
									go = 1'b1;
								end
							end else if (in_byte == CH_SLASH) begin
								sp_v = 1'b1;
							end else if (is_space(in_byte) || is_special(in_byte)) begin
								evs[n[EV_IDX_W-1:0]] = mk(EV_ID_END, 8'd0, hl_v, hc_v);
								n = n + 1'b1;
								mode_v = M_WS;
								go = 1'b1;
							end else begin
								evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, in_byte, hl_v, hc_v);
								n = n + 1'b1;
							end
						end
						M_SQ: begin
							if (qp_v) begin
								qp_v = 1'b0;
								if (in_byte == CH_SQUOTE) begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, CH_SQUOTE, hl_v, hc_v);
									n = n + 1'b1;
								end else begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_END, 8'd0, hl_v, hc_v);
									n = n + 1'b1;
									mode_v = M_WS;
									go = 1'b1;
								end
							end else if (sp_v) begin
								sp_v = 1'b0;
								if (in_byte == CH_SLASH) begin
									mode_v = M_LINE;
									ret_v = M_SQ;
								end else if (in_byte == CH_STAR) begin
									mode_v = M_BLOCK;
									ret_v = M_SQ;
									star_v = 1'b0;
								end else begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, CH_SLASH, hl_v, hc_v);
									n = n + 1'b1;
									go = 1'b1;
								end
							end else if (in_byte == CH_SQUOTE) begin
								qp_v = 1'b1;
							end else if (in_byte == CH_SLASH) begin
								sp_v = 1'b1;
							end else begin
								evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, in_byte, hl_v, hc_v);
								n = n + 1'b1;
							end
						end
						M_DQ: begin
							if (qp_v) begin
								qp_v = 1'b0;
								if (in_byte == CH_DQUOTE) begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, CH_DQUOTE, hl_v, hc_v);
									n = n + 1'b1;
								end else begin
									evs[n[EV_IDX_W-1:0]] = mk(EV_ID_END, 8'd0, hl_v, hc_v);
									n = n + 1'b1;
									mode_v = M_WS;
									go = 1'b1;
								end
							end else if (in_byte == CH_DQUOTE) begin
								qp_v = 1'b1;
							end else begin
								evs[n[EV_IDX_W-1:0]] = mk(EV_ID_CHAR, in_byte, hl_v, hc_v);
								n = n + 1'b1;
							end
						end
						M_LINE: begin
							// the newline is seen again by the enclosing mode
							if (in_byte == CH_NL) begin
								mode_v = ret_v;
								go = 1'b1;
							end
						end
						M_BLOCK: begin
							if (star_v && in_byte == CH_SLASH) begin
								star_v = 1'b0;
								mode_v = ret_v;
							end else begin
								star_v = (in_byte == CH_STAR);
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign bundle.ev    = evs;
	assign bundle.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_WS;
			ret_q  <= M_WS;
			sp_q   <= 1'b0;
			qp_q   <= 1'b0;
			star_q <= 1'b0;
			line_q <= LINE_BITS'(1);
			col_q  <= COLUMN_BITS'(1);
			hl_q   <= LINE_BITS'(1);
			hc_q   <= COLUMN_BITS'(1);
		end else if (step) begin
			mode_q <= mode_v;
			ret_q  <= ret_v;
			sp_q   <= sp_v;
			qp_q   <= qp_v;
			star_q <= star_v;
			hl_q   <= hl_v;
			hc_q   <= hc_v;
			// position counters saturate
			if (!eot && mode_q != M_DONE) begin
				if (in_byte == CH_NL) begin
					if (!(&line_q)) line_q <= line_q + 1'b1;
					col_q <= COLUMN_BITS'(1);
				end else if (!(&col_q)) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_DONE |=> mode_q == M_DONE)
		else $error("lexer left the finished mode");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_DONE |-> bundle.count == '0)
		else $error("events raised after end of text");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0 && col_q != '0 && hl_q != '0 && hc_q != '0)
		else $error("position counter reached zero");
`endif

endmodule

`default_nettype wire

### hdl/stt_outbuf.sv
// result register holding the events of one input word
// hands them out one event per cycle in order while out_stall is low; uses stt_pkg
`default_nettype none

module stt_outbuf import stt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire ev_bundle_t       bundle,
	output logic                  ready,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [3:0]            event_kind,
	output logic [7:0]            id_byte,
	output logic [LINE_BITS-1:0]   tok_line,
	output logic [COLUMN_BITS-1:0] tok_column,
	output logic                  last_of_run
);

	event_t [MAX_EV-1:0]   ev_q;
	logic [EV_CNT_W-1:0]   cnt_q;
	logic [EV_IDX_W-1:0]   idx_q;
	logic                  take, last_ev;
	event_t                cur;

	assign out_valid = (cnt_q != '0);
	assign take      = out_valid && !out_stall;
	assign last_ev   = (EV_CNT_W'(idx_q) + 1'b1 == cnt_q);
	// free once the final event of the held group leaves
	assign ready     = !out_valid || (take && last_ev);

	assign cur         = ev_q[idx_q];
	assign event_kind  = cur.kind;
	assign id_byte     = cur.id_byte;
	assign tok_line    = cur.line;
	assign tok_column  = cur.column;
	assign last_of_run = last_ev;

	always_ff @(posedge clk) begin
		if (load) ev_q <= bundle.ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.count;
			idx_q <= '0;
		end else if (take) begin
			if (last_ev) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= EV_CNT_W'(MAX_EV))
		else $error("event count beyond group size");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> EV_CNT_W'(idx_q) < cnt_q)
		else $error("read index outside held group");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_ev && !load |=> idx_q == $past(idx_q) + 1'b1)
		else $error("read index did not advance");
`endif

endmodule

`default_nettype wire

### hdl/structured_text_tokenizer.sv
// top level of the structured text tokenizer
// input register, stt_lexer and stt_outbuf; uses stt_pkg
//
//  channel | handshake                 | payload
//  input   | in_valid / in_stall       | in_byte, end_of_text
//  output  | out_valid / out_stall     | event_kind, id_byte, tok_line, tok_column,
//          |                           | last_of_run
//
// a word waits in the input register, then the lexer raises its
// events (zero to four) into the result register in one pass
// the result register sends one event per cycle while out_stall is low, and a new
// word waits in the input register until the last held event leaves; words raising none pass at one a cycle
// reset returns the lexer to whitespace skipping at line 1, column 1
// an output stall backs up into the input register and then raises in_stall
`default_nettype none

module structured_text_tokenizer import stt_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   end_of_text,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [3:0]                  event_kind,
	output logic [7:0]                  id_byte,
	output logic [LINE_BITS-1:0]        tok_line,
	output logic [COLUMN_BITS-1:0]      tok_column,
	output logic                        last_of_run
);

	logic       valid_s1, eot_s1;
	logic [7:0] byte_s1;
	logic       buf_ready, advance;
	ev_bundle_t bundle;

	assign advance  = valid_s1 && buf_ready;
	assign in_stall = valid_s1 && !buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eot_s1  <= end_of_text;
		end
	end

	stt_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.eot     (eot_s1),
		.bundle  (bundle)
	);

	stt_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.bundle      (bundle),
		.ready       (buf_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.id_byte     (id_byte),
		.tok_line    (tok_line),
		.tok_column  (tok_column),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

### verif/structured_text_tokenizer_tb.sv
// self-checking testbench for structured_text_tokenizer
// drives text bytes and an end mark, predicts every token event and checks it; uses stt_pkg
`default_nettype none

module structured_text_tokenizer_tb;
	import stt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 16;
	localparam int MAX_GAP        = 30;
	localparam int RANDOM_WORDS   = 85;
	localparam int LONG_LINE      = 20;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef enum logic [2:0] {
		LX_WS, LX_BARE, LX_SQ, LX_DQ, LX_LINE, LX_BLOCK, LX_DONE
	} lex_mode_t;

	typedef struct {
		ev_kind_t               kind;
		logic [7:0]             id_byte;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] column;
		logic                   last;
	} tok_event_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             in_byte;
	logic                   end_of_text;
	logic                   out_valid;
	logic                   out_stall;
	logic [3:0]             event_kind;
	logic [7:0]             id_byte;
	logic [LINE_BITS-1:0]   tok_line;
	logic [COLUMN_BITS-1:0] tok_column;
	logic                   last_of_run;

	// lexer model state
	lex_mode_t              lx_mode;
	lex_mode_t              lx_return;
	logic                   slash_pend;
	logic                   quote_pend;
	logic                   star_seen;
	logic [LINE_BITS-1:0]   cur_line;
	logic [COLUMN_BITS-1:0] cur_col;
	logic [LINE_BITS-1:0]   id_line;
	logic [COLUMN_BITS-1:0] id_col;

	tok_event_t step_events[$];
	tok_event_t expected_events[$];
	logic [7:0] frag_bytes[$];

	int    send_idle_pct;
	int    recv_idle_pct;
	bit    hold_request;
	int    hold_left;
	int    fail_count;
	int    words_sent;
	int    events_checked;
	string ending_case;

	structured_text_tokenizer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.id_byte     (id_byte),
		.tok_line    (tok_line),
		.tok_column  (tok_column),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_punct(input logic [7:0] c);
		return c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK ||
			c == CH_COMMA || c == CH_COLON || c == CH_HASH;
	endfunction

	function automatic ev_kind_t punct_kind(input logic [7:0] c);
		case (c)
			CH_LBRACE: return EV_LBRACE;
			CH_RBRACE: return EV_RBRACE;
			CH_LBRACK: return EV_LBRACK;
			CH_RBRACK: return EV_RBRACK;
			CH_COMMA:  return EV_COMMA;
			CH_COLON:  return EV_COLON;
			default:   return EV_HASH;
		endcase
	endfunction

	function automatic logic [7:0] punct_char(input int idx);
		case (idx)
			0:       return CH_LBRACE;
			1:       return CH_RBRACE;
			2:       return CH_LBRACK;
			3:       return CH_RBRACK;
			4:       return CH_COMMA;
			5:       return CH_COLON;
			default: return CH_HASH;
		endcase
	endfunction

	function automatic void raise(input ev_kind_t kind, input logic [7:0] b,
		input logic [LINE_BITS-1:0] ln, input logic [COLUMN_BITS-1:0] col);
		tok_event_t ev;
		if (step_events.size() < MAX_EV) begin
			ev.kind = kind;
			ev.id_byte = b;
			ev.line = ln;
			ev.column = col;
			ev.last = 1'b0;
			step_events = {step_events, ev};
		end
	endfunction

	// settles a held slash against c; true when a comment opens
	function automatic bit opens_comment(input logic [7:0] c, input lex_mode_t ret);
		if (c == CH_SLASH) begin
			lx_mode = LX_LINE;
			lx_return = ret;
			return 1'b1;
		end
		if (c == CH_STAR) begin
			lx_mode = LX_BLOCK;
			lx_return = ret;
			star_seen = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void lex_byte(input logic [7:0] c);
		bit again;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (lx_mode)
				LX_WS: begin
					if (slash_pend) begin
						slash_pend = 1'b0;
						if (!opens_comment(c, LX_WS)) begin
							raise(EV_ID_BEGIN, 8'h00, id_line, id_col);
							raise(EV_ID_CHAR, CH_SLASH, id_line, id_col);
							lx_mode = LX_BARE;
							again = 1'b1;
						end
					end else if (is_space(c)) begin
					end else if (c == CH_SLASH) begin
						slash_pend = 1'b1;
						id_line = cur_line;
						id_col = cur_col;
					end else if (is_punct(c)) begin
						raise(punct_kind(c), 8'h00, cur_line, cur_col);
					end else begin
						id_line = cur_line;
						id_col = cur_col;
						raise(EV_ID_BEGIN, 8'h00, cur_line, cur_col);
						quote_pend = 1'b0;
						if (c == CH_SQUOTE) lx_mode = LX_SQ;
						else if (c == CH_DQUOTE) lx_mode = LX_DQ;
						else begin
							raise(EV_ID_CHAR, c, cur_line, cur_col);
							lx_mode = LX_BARE;
						end
					end
				end
				LX_BARE: begin
					if (slash_pend) begin
						slash_pend = 1'b0;
						if (!opens_comment(c, LX_BARE)) begin
							raise(EV_ID_CHAR, CH_SLASH, id_line, id_col);
							again = 1'b1;
						end
					end else if (c == CH_SLASH) begin
						slash_pend = 1'b1;
					end else if (is_space(c) || is_punct(c)) begin
						raise(EV_ID_END, 8'h00, id_line, id_col);
						lx_mode = LX_WS;
						again = 1'b1;
					end else begin
						raise(EV_ID_CHAR, c, id_line, id_col);
					end
				end
				LX_SQ: begin
					if (quote_pend) begin
						quote_pend = 1'b0;
						if (c == CH_SQUOTE) raise(EV_ID_CHAR, CH_SQUOTE, id_line, id_col);
						else begin
							raise(EV_ID_END, 8'h00, id_line, id_col);
							lx_mode = LX_WS;
							again = 1'b1;
						end
					end else if (slash_pend) begin
						slash_pend = 1'b0;
						if (!opens_comment(c, LX_SQ)) begin
							raise(EV_ID_CHAR, CH_SLASH, id_line, id_col);
							again = 1'b1;
						end
					end else if (c == CH_SQUOTE) begin
						quote_pend = 1'b1;
					end else if (c == CH_SLASH) begin
						slash_pend = 1'b1;
					end else begin
						raise(EV_ID_CHAR, c, id_line, id_col);
					end
				end
				LX_DQ: begin
					if (quote_pend) begin
						quote_pend = 1'b0;
						if (c == CH_DQUOTE) raise(EV_ID_CHAR, CH_DQUOTE, id_line, id_col);
						else begin
							raise(EV_ID_END, 8'h00, id_line, id_col);
							lx_mode = LX_WS;
							again = 1'b1;
						end
					end else if (c == CH_DQUOTE) begin
						quote_pend = 1'b1;
					end else begin
						raise(EV_ID_CHAR, c, id_line, id_col);
					end
				end
				LX_LINE: begin
					// the newline is seen again by the enclosing mode
					if (c == CH_NL) begin
						lx_mode = lx_return;
						again = 1'b1;
					end
				end
				LX_BLOCK: begin
					if (star_seen && c == CH_SLASH) begin
						star_seen = 1'b0;
						lx_mode = lx_return;
					end else begin
						star_seen = (c == CH_STAR);
					end
				end
				default: begin
				end
			endcase
		end
	endfunction

	function automatic void lex_end();
		if (lx_mode == LX_LINE) lx_mode = lx_return;
		case (lx_mode)
			LX_WS: begin
				if (slash_pend) begin
					raise(EV_ID_BEGIN, 8'h00, id_line, id_col);
					raise(EV_ID_CHAR, CH_SLASH, id_line, id_col);
					raise(EV_ID_END, 8'h00, id_line, id_col);
				end
				raise(EV_END, 8'h00, cur_line, cur_col);
			end
			LX_BARE: begin
				if (slash_pend) raise(EV_ID_CHAR, CH_SLASH, id_line, id_col);
				raise(EV_ID_END, 8'h00, id_line, id_col);
				raise(EV_END, 8'h00, cur_line, cur_col);
			end
			LX_SQ, LX_DQ: begin
				if (quote_pend) begin
					raise(EV_ID_END, 8'h00, id_line, id_col);
					raise(EV_END, 8'h00, cur_line, cur_col);
				end else begin
					raise(EV_ERROR, 8'h00, cur_line, cur_col);
				end
			end
			LX_BLOCK: raise(EV_ERROR, 8'h00, cur_line, cur_col);
			default: return;
		endcase
		lx_mode = LX_DONE;
		slash_pend = 1'b0;
		quote_pend = 1'b0;
		star_seen = 1'b0;
	endfunction

	function automatic void predict_events(input logic [7:0] c, input logic eot);
		step_events.delete();
		if (eot) begin
			lex_end();
		end else if (lx_mode != LX_DONE) begin
			lex_byte(c);
			if (c == CH_NL) begin
				if (cur_line != {LINE_BITS{1'b1}}) cur_line++;
				cur_col = COLUMN_BITS'(1);
			end else if (cur_col != {COLUMN_BITS{1'b1}}) begin
				cur_col++;
			end
		end
		if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
		expected_events = {expected_events, step_events};
	endfunction

	task automatic send_word(input logic [7:0] b, input logic eot);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_text <= eot;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predict_events(b, eot);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
	endtask

	task automatic send_fragment();
		logic [7:0] b;
		while (frag_bytes.size() > 0) begin
			b = frag_bytes[0];
			frag_bytes.delete(0);
			send_word(b, 1'b0);
		end
	endtask

	function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c == a || c == b);
		return c;
	endfunction

	function automatic void append_frag(input logic [7:0] b);
		frag_bytes = {frag_bytes, b};
	endfunction

	function automatic logic [7:0] bare_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (is_space(c) || is_punct(c) || c == CH_SLASH);
		return c;
	endfunction

	function automatic void push_line_comment();
		append_frag(CH_SLASH);
		append_frag(CH_SLASH);
		repeat ($urandom_range(4)) append_frag(byte_except(CH_NL, CH_NL));
		append_frag(CH_NL);
	endfunction

	// body never holds a slash, so it cannot close early
	function automatic void push_block_comment();
		append_frag(CH_SLASH);
		append_frag(CH_STAR);
		repeat ($urandom_range(4)) begin
			if ($urandom_range(3) == 0) append_frag(CH_STAR);
			else append_frag(byte_except(CH_SLASH, CH_SLASH));
		end
		append_frag(CH_STAR);
		append_frag(CH_SLASH);
	endfunction

	function automatic void build_fragment();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0, 9: append_frag(punct_char($urandom_range(6)));
			1: repeat ($urandom_range(3, 1)) begin
				if ($urandom_range(2) == 0) append_frag(CH_SPACE);
				else append_frag(8'($urandom_range(CH_CR, CH_TAB)));
			end
			2, 3: begin
				repeat ($urandom_range(6, 1)) begin
					sel = $urandom_range(9);
					if (sel == 0) push_block_comment();
					else if (sel == 1) begin
						append_frag(CH_SLASH);
						append_frag(bare_byte());
					end else append_frag(bare_byte());
				end
				sel = $urandom_range(3);
				if (sel == 0) push_line_comment();
				else if (sel == 1) append_frag(punct_char($urandom_range(6)));
				else append_frag(CH_SPACE);
			end
			4: begin
				append_frag(CH_SQUOTE);
				repeat ($urandom_range(6)) begin
					sel = $urandom_range(9);
					if (sel == 0) begin
						append_frag(CH_SQUOTE);
						append_frag(CH_SQUOTE);
					end else if (sel == 1) push_line_comment();
					else if (sel == 2) push_block_comment();
					else if (sel == 3) begin
						append_frag(CH_SLASH);
						append_frag(byte_except(CH_SLASH, CH_STAR));
					end else append_frag(byte_except(CH_SLASH, CH_SQUOTE));
				end
				append_frag(CH_SQUOTE);
			end
			5: begin
				append_frag(CH_DQUOTE);
				repeat ($urandom_range(6)) begin
					if ($urandom_range(4) == 0) begin
						append_frag(CH_DQUOTE);
						append_frag(CH_DQUOTE);
					end else append_frag(byte_except(CH_DQUOTE, CH_DQUOTE));
				end
				append_frag(CH_DQUOTE);
			end
			6: push_line_comment();
			7: push_block_comment();
			default: append_frag(8'($urandom_range(255)));
		endcase
	endfunction

	// steers the lexer back to plain whitespace skipping from wherever it is
	task automatic return_to_whitespace();
		while (lx_mode != LX_WS || slash_pend) begin
			case (lx_mode)
				LX_BLOCK: begin
					send_word(CH_STAR, 1'b0);
					send_word(CH_SLASH, 1'b0);
				end
				LX_LINE: send_word(CH_NL, 1'b0);
				LX_SQ: begin
					if (quote_pend) send_word(CH_SPACE, 1'b0);
					else if (slash_pend) send_word("a", 1'b0);
					else send_word(CH_SQUOTE, 1'b0);
				end
				LX_DQ: send_word(quote_pend ? CH_SPACE : CH_DQUOTE, 1'b0);
				default: send_word(CH_SPACE, 1'b0);
			endcase
		end
	endtask

	task automatic test_punctuation();
		send_text("{}[],:#");
	endtask

	// slash then a stop raises begin, char, end and the stop in one go
	task automatic test_lone_slash();
		send_text("/,");
	endtask

	// the star that opens a block comment must not help close it
	task automatic test_comments_in_bare();
		send_word(8'hFF, 1'b0);
		send_text("/*/*/");
		send_word(8'h00, 1'b0);
		send_text("//\n");
	endtask

	task automatic test_single_quoted();
		send_text("'//\n''' ");
	endtask

	task automatic test_double_quoted();
		send_text("\"/*\"\"\" ");
	endtask

	// a run of spaces moves the identifier well along the line
	task automatic test_long_line();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (LONG_LINE) send_word(CH_SPACE, 1'b0);
		send_text("ab,\n");
	endtask

	task automatic test_random_text(input int send_pct, input int recv_pct);
		int stop_at;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			build_fragment();
			send_fragment();
		end
	endtask

	task automatic test_backpressure();
		return_to_whitespace();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		send_word(CH_SPACE, 1'b0);
		repeat (24) send_word(8'("a") + 8'($urandom_range(25)), 1'b0);
		send_word(CH_SPACE, 1'b0);
	endtask

	task automatic test_end_of_text();
		send_idle_pct = 35;
		recv_idle_pct = 82;
		return_to_whitespace();
		case ($urandom_range(5))
			0: begin
				ending_case = "open block comment";
				send_text("/* x");
			end
			1: begin
				ending_case = "open single quote";
				send_text("'ab");
			end
			2: begin
				ending_case = "closed double quote";
				send_text("\"ab\"");
			end
			3: begin
				ending_case = "lone slash";
				send_text(" /");
			end
			4: begin
				ending_case = "bare with held slash";
				send_text(" ab/");
			end
			default: begin
				ending_case = "line comment in bare";
				send_text(" ab//zz");
			end
		endcase
		send_word(8'($urandom_range(255)), 1'b1);
		// everything after the end mark is dropped
		repeat (4) send_word(8'($urandom_range(255)), 1'b0);
		send_word(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		tok_event_t want;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event: kind %0d line %0d column %0d",
						event_kind, tok_line, tok_column);
					fail_count++;
				end else begin
					want = expected_events[0];
					expected_events.delete(0);
					events_checked++;
					if (event_kind !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
						fail_count++;
					end
					if (id_byte !== want.id_byte) begin
						$error("id_byte: expected %0h, got %0h", want.id_byte, id_byte);
						fail_count++;
					end
					if (tok_line !== want.line) begin
						$error("tok_line: expected %0d, got %0d", want.line, tok_line);
						fail_count++;
					end
					if (tok_column !== want.column) begin
						$error("tok_column: expected %0d, got %0d", want.column, tok_column);
						fail_count++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_text = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		fail_count = 0;
		words_sent = 0;
		events_checked = 0;
		ending_case = "";
		send_idle_pct = 35;
		recv_idle_pct = 82;
		lx_mode = LX_WS;
		lx_return = LX_WS;
		slash_pend = 1'b0;
		quote_pend = 1'b0;
		star_seen = 1'b0;
		cur_line = LINE_BITS'(1);
		cur_col = COLUMN_BITS'(1);
		id_line = LINE_BITS'(1);
		id_col = COLUMN_BITS'(1);
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_punctuation();
		test_lone_slash();
		test_comments_in_bare();
		test_single_quoted();
		test_double_quoted();
		test_long_line();
		test_random_text(35, 82);
		test_random_text(82, 35);
		test_random_text(0, 0);
		test_backpressure();
		test_end_of_text();

		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input words and %0d token events, text ended on %s",
			words_sent, events_checked, ending_case);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
